### rtl/vfgc_pkg.sv
// Shared constants, types and helpers of the vehicle footprint grid cell unit.
package vfgc_pkg;

   // Lattice size: points per row and per column, both ends included.
   localparam int SAMPLES = 30;
   localparam int N1      = SAMPLES - 1;
   localparam int DSCALE  = 2 * N1;
   localparam int COLW    = 6;

   // Angles in Q8 degrees.
   localparam int QUARTER = 23040;
   localparam int HALF    = 46080;
   localparam int THREE_Q = 69120;
   localparam int FULL    = 92160;

   // Quarter-wave sine polynomial coefficients.
   localparam int SIN_A = 51472;
   localparam int SIN_B = 21024;
   localparam int SIN_C = 2320;

   // Division by 45 as a multiplication by a rounded-up reciprocal.
   localparam int Z_RECIP = 2982617;
   localparam int Z_SHIFT = 27;

   // Datapath widths.
   localparam int TW = 17;  // sine and cosine, signed Q1.15
   localparam int XW = 26;  // scaled lattice x
   localparam int YW = 24;  // scaled lattice y
   localparam int PW = 45;  // rotated point before scaling
   localparam int AW = 42;  // dividend, signed
   localparam int UW = 41;  // dividend magnitude after the floor fold
   localparam int DW = 23;  // divisor: grid spacing times the lattice scale

   // Pipeline depth: stage 0, sine, rotation and sum, divider.
   localparam int LAT = 1 + 5 + 2 + UW + 1;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      CSR_AXLE_TO_FRONT  = 2'd0,
      CSR_VEHICLE_LENGTH = 2'd1,
      CSR_VEHICLE_WIDTH  = 2'd2,
      CSR_GRID_SPACING   = 2'd3
   } csr_index_type;

   // Angle within its quadrant and the sign of the sine there.
   typedef struct packed {
      logic [14:0] tt;
      logic        neg;
   } quarter_type;

   // Split an angle in [0, FULL) into a quarter-wave argument and a sign.
   function automatic quarter_type quarter_of(input logic [16:0] a);
      quarter_type r;
      priority if (a >= 17'(THREE_Q)) begin
         r.tt  = 15'(17'(FULL) - a);
         r.neg = 1'b1;
      end else if (a >= 17'(HALF)) begin
         r.tt  = 15'(a - 17'(HALF));
         r.neg = 1'b1;
      end else if (a >= 17'(QUARTER)) begin
         r.tt  = 15'(17'(HALF) - a);
         r.neg = 1'b0;
      end else begin
         r.tt  = a[14:0];
         r.neg = 1'b0;
      end
      return r;
   endfunction

endpackage

### rtl/vfgc_ifs.sv
// Valid/ready channel interfaces for input items and result cells.
interface vfgc_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] ego_pos_x;
   logic signed [31:0] ego_pos_y;
   logic signed [17:0] heading;
   logic signed [31:0] origin_x;
   logic signed [31:0] origin_y;
   logic        [4:0]  row_index;

   modport source(output valid, ego_pos_x, ego_pos_y, heading, origin_x, origin_y,
                  row_index, input ready);
   modport sink(input valid, ego_pos_x, ego_pos_y, heading, origin_x, origin_y,
                row_index, output ready);
endinterface

interface vfgc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] cell_x;
   logic [15:0] cell_y;
   logic        last_cell;

   modport source(output valid, cell_x, cell_y, last_cell, input ready);
   modport sink(input valid, cell_x, cell_y, last_cell, output ready);
endinterface

### rtl/vfgc_qsin.sv
// Five-stage pipelined quarter-wave sine with sign.
module vfgc_qsin
   import vfgc_pkg::*;
(
   input  logic                 clock,
   input  logic                 en,
   input  quarter_type          arg,
   output logic signed [TW-1:0] value
);

   logic [15:0] z1_ff, z1_in, z2_ff, z3_ff, z4_ff;
   logic [15:0] zz2_ff, zz2_in, zz3_ff;
   logic [14:0] inner_ff, inner_in;
   logic [15:0] poly_ff, poly_in;
   logic signed [TW-1:0] value_ff, value_in;
   logic [3:0]  neg_ff;
   logic [20:0] num;
   logic [43:0] zprod;
   logic [31:0] sq;
   logic [27:0] zc;
   logic [30:0] zi;
   logic [32:0] zp;
   logic [16:0] mag;

   // Stage math: z, z squared, inner term, polynomial, final product.
   always_comb begin
      num      = {arg.tt, 6'b0} + 21'd22;
      zprod    = 44'(num) * 44'(Z_RECIP);
      z1_in    = 16'(zprod >> Z_SHIFT);
      sq       = 32'(z1_ff) * 32'(z1_ff);
      zz2_in   = 16'(sq >> 15);
      zc       = 28'(zz2_ff) * 28'(SIN_C);
      inner_in = 15'(15'(SIN_B) - 15'(zc >> 15));
      zi       = 31'(zz3_ff) * 31'(inner_ff);
      poly_in  = 16'(16'(SIN_A) - 16'(zi >> 15));
      zp       = 33'(z4_ff) * 33'(poly_ff) + 33'd16384;
      mag      = 17'(zp >> 15);
      value_in = neg_ff[3] ? -$signed(mag) : $signed(mag);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z1_ff    <= z1_in;
         z2_ff    <= z1_ff;
         zz2_ff   <= zz2_in;
         z3_ff    <= z2_ff;
         zz3_ff   <= zz2_ff;
         inner_ff <= inner_in;
         z4_ff    <= z3_ff;
         poly_ff  <= poly_in;
         value_ff <= value_in;
         neg_ff   <= {neg_ff[2:0], arg.neg};
      end
   end

   assign value = value_ff;

endmodule

### rtl/vfgc_div.sv
// Pipelined restoring floor divider, one quotient bit per stage.
module vfgc_div
   import vfgc_pkg::*;
(
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [AW-1:0] dividend,
   input  logic        [DW-1:0] divisor,
   output logic        [15:0]   quotient
);

   logic [DW-1:0] rem_ff [0:UW];
   logic [DW-1:0] rem_in [1:UW];
   logic [UW-1:0] dq_ff  [0:UW];
   logic [UW-1:0] dq_in  [1:UW];
   logic [DW-1:0] dvs_ff [0:UW];
   logic          neg_ff [0:UW];
   logic [DW:0]   trial  [1:UW];
   logic          ge     [1:UW];

   // A negative dividend is folded: floor(a/d) = ~floor(~a/d).
   always_comb begin
      for (int k = 1; k <= UW; k++) begin
         trial[k] = {rem_ff[k-1], dq_ff[k-1][UW-1]};
         ge[k]    = trial[k] >= {1'b0, dvs_ff[k-1]};
         rem_in[k] = ge[k] ? DW'(trial[k] - {1'b0, dvs_ff[k-1]}) : DW'(trial[k]);
         dq_in[k]  = {dq_ff[k-1][UW-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= '0;
         dq_ff[0]  <= dividend[AW-1] ? ~dividend[UW-1:0] : dividend[UW-1:0];
         dvs_ff[0] <= divisor;
         neg_ff[0] <= dividend[AW-1];
         for (int k = 1; k <= UW; k++) begin
            rem_ff[k] <= rem_in[k];
            dq_ff[k]  <= dq_in[k];
            dvs_ff[k] <= dvs_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
      end
   end

   assign quotient = dq_ff[UW][15:0] ^ {16{neg_ff[UW]}};

endmodule

### rtl/vehicle_footprint_grid_cells_unit.sv
// Top level: rotated vehicle footprint rasterizer; one grid cell per cycle
// while the output does not stall.
//   channel   direction  handshake          word
//   req_chan  in         valid/ready        pose, anchor, row index
//   rsp_chan  out        valid/ready        cell_x, cell_y, last_cell
//   csr_*     in         write enable only  16-bit register write
//
// Each request word yields SAMPLES cells, one per column; the column sequencer
// takes the next request word as it sequences the last column.
// After it is sequenced, a cell passes stage 0, sine, rotation, sum and divider;
// the quotient divider (one bit per stage) sets most of the pipeline depth.
// Synchronous reset clears the sequencer and all valid bits, not the payload.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module vehicle_footprint_grid_cells_unit
   import vfgc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   vfgc_req_if.sink      req_chan,
   vfgc_rsp_if.source    rsp_chan,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  logic [15:0]   csr_wdata
);

   // Configuration registers.
   logic [15:0] axle_ff, len_ff, wid_ff, grid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         axle_ff <= 16'd3891;
         len_ff  <= 16'd4915;
         wid_ff  <= 16'd1946;
         grid_ff <= 16'd102;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_AXLE_TO_FRONT:  axle_ff <= csr_wdata;
            CSR_VEHICLE_LENGTH: len_ff  <= csr_wdata;
            CSR_VEHICLE_WIDTH:  wid_ff  <= csr_wdata;
            CSR_GRID_SPACING:   grid_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pipeline advances whenever the output stage is empty or being taken.
   logic           en;
   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] last_ff;

   assign en = !vld_ff[LAT-1] || rsp_chan.ready;

   // Column sequencer: holds the request word and walks j over the row.
   logic              busy_ff;
   logic [COLW-1:0]   col_ff;
   logic signed [31:0] ex_ff, ey_ff, ox_ff, oy_ff;
   logic signed [17:0] yaw_ff;
   logic [4:0]         row_ff;
   logic               col_end;
   logic               accept;

   assign col_end        = col_ff == COLW'(N1);
   assign req_chan.ready = !busy_ff || (en && col_end);
   assign accept         = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         col_ff  <= '0;
      end else if (accept) begin
         busy_ff <= 1'b1;
         col_ff  <= '0;
      end else if (en && busy_ff) begin
         if (col_end) begin
            busy_ff <= 1'b0;
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ex_ff  <= req_chan.ego_pos_x;
         ey_ff  <= req_chan.ego_pos_y;
         yaw_ff <= req_chan.heading;
         ox_ff  <= req_chan.origin_x;
         oy_ff  <= req_chan.origin_y;
         row_ff <= req_chan.row_index;
      end
   end

   // Stage 0: angle reduction, lattice point, offsets and divisor.
   logic signed [19:0]   ang_v;
   logic [16:0]          ang_s;
   logic [17:0]          ang_c;
   logic [COLW-1:0]      row_c;
   logic signed [17:0]   rear;
   logic signed [XW-1:0] xd_in;
   logic signed [YW-1:0] yd_in, jm;
   logic signed [32:0]   dx_in, dy_in;
   logic [15:0]          g_eff;
   logic [DW-1:0]        d2_in;
   quarter_type          qs_in, qc_in;

   always_comb begin
      ang_v = 20'(QUARTER) - 20'(yaw_ff);
      if (ang_v < 0) ang_v = ang_v + 20'(FULL);
      if (ang_v < 0) ang_v = ang_v + 20'(FULL);
      if (ang_v >= 20'(FULL)) ang_v = ang_v - 20'(FULL);
      ang_s = ang_v[16:0];
      ang_c = {1'b0, ang_s} + 18'(QUARTER);
      if (ang_c >= 18'(FULL)) ang_c = ang_c - 18'(FULL);
      qs_in = quarter_of(ang_s);
      qc_in = quarter_of(ang_c[16:0]);

      row_c = ({1'b0, row_ff} > COLW'(N1)) ? COLW'(N1) : COLW'(row_ff);
      rear  = $signed({2'b0, axle_ff}) - $signed({2'b0, len_ff});
      xd_in = XW'(rear) * XW'(DSCALE) + XW'({1'b0, len_ff}) * XW'({row_c, 1'b0});
      jm    = YW'({col_ff, 1'b0}) - YW'(N1);
      yd_in = YW'({1'b0, wid_ff}) * jm;
      dx_in = {ex_ff[31], ex_ff} - {ox_ff[31], ox_ff};
      dy_in = {ey_ff[31], ey_ff} - {oy_ff[31], oy_ff};
      g_eff = (grid_ff == '0) ? 16'd1 : grid_ff;
      d2_in = DW'(g_eff) * DW'(DSCALE);
   end

   quarter_type          qs_ff, qc_ff;
   logic signed [XW-1:0] xd_ff [0:5];
   logic signed [YW-1:0] yd_ff [0:5];
   logic signed [32:0]   dx_ff [0:5];
   logic signed [32:0]   dy_ff [0:5];
   logic [DW-1:0]        d2_ff [0:7];

   always_ff @(posedge clock) begin
      if (en) begin
         qs_ff    <= qs_in;
         qc_ff    <= qc_in;
         xd_ff[0] <= xd_in;
         yd_ff[0] <= yd_in;
         dx_ff[0] <= dx_in;
         dy_ff[0] <= dy_in;
         d2_ff[0] <= d2_in;
         for (int k = 1; k <= 5; k++) begin
            xd_ff[k] <= xd_ff[k-1];
            yd_ff[k] <= yd_ff[k-1];
            dx_ff[k] <= dx_ff[k-1];
            dy_ff[k] <= dy_ff[k-1];
         end
         for (int k = 1; k <= 7; k++) begin
            d2_ff[k] <= d2_ff[k-1];
         end
      end
   end

   // Stages 1 to 5: sine and cosine.
   logic signed [TW-1:0] sin_v, cos_v;

   vfgc_qsin u_sin (.clock(clock), .en(en), .arg(qs_ff), .value(sin_v));
   vfgc_qsin u_cos (.clock(clock), .en(en), .arg(qc_ff), .value(cos_v));

   // Stage 6: rotation products and scaled offsets.
   logic signed [PW-1:0] pcx_ff, psy_ff, psx_ff, pcy_ff;
   logic signed [AW-1:0] dxs_ff, dys_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pcx_ff <= PW'(cos_v) * PW'(xd_ff[5]);
         psy_ff <= PW'(sin_v) * PW'(yd_ff[5]);
         psx_ff <= PW'(sin_v) * PW'(xd_ff[5]);
         pcy_ff <= PW'(cos_v) * PW'(yd_ff[5]);
         dxs_ff <= AW'(dx_ff[5]) * AW'(DSCALE);
         dys_ff <= AW'(dy_ff[5]) * AW'(DSCALE);
      end
   end

   // Stage 7: sum and drop the Q15 fraction (floor), giving the dividends.
   logic signed [PW-1:0] mx, my;
   logic signed [AW-1:0] ax_ff, ay_ff;

   assign mx = pcx_ff - psy_ff;
   assign my = psx_ff + pcy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff <= AW'(mx >>> 15) + dxs_ff;
         ay_ff <= AW'(my >>> 15) + dys_ff;
      end
   end

   // Stages 8 onward: floor division by grid spacing times lattice scale.
   vfgc_div u_div_x (.clock(clock), .en(en), .dividend(ax_ff), .divisor(d2_ff[7]),
                     .quotient(rsp_chan.cell_x));
   vfgc_div u_div_y (.clock(clock), .en(en), .dividend(ay_ff), .divisor(d2_ff[7]),
                     .quotient(rsp_chan.cell_y));

   // Valid and last-cell flags travel alongside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], busy_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         last_ff <= {last_ff[LAT-2:0], col_end};
      end
   end

   assign rsp_chan.valid     = vld_ff[LAT-1];
   assign rsp_chan.last_cell = last_ff[LAT-1];

endmodule
